// ===== sv/trr_pkg.sv =====
package trr_pkg;

    localparam logic [1:0] PH_SEEK  = 2'd0;
    localparam logic [1:0] PH_REC   = 2'd1;
    localparam logic [1:0] PH_TRAIL = 2'd2;

    localparam logic [2:0] K_DATA = 3'd0;
    localparam logic [2:0] K_END  = 3'd1;
    localparam logic [2:0] K_MARK = 3'd2;
    localparam logic [2:0] K_EOM  = 3'd3;
    localparam logic [2:0] K_BAD  = 3'd4;

    localparam logic [8:0] SYM_NULL = 9'h000;
    localparam logic [8:0] SYM_MARK = 9'h01C;
    localparam logic [8:0] SYM_EOR  = 9'h01E;
    localparam logic [8:0] SYM_GAP  = 9'h07F;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data_byte;
        logic [15:0] byte_count;
        logic        end_of_record;
        logic        bad_close;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [1:0] phase;
        logic       eor_seen;
        logic       error_seen;
    } flags_t;

    localparam result_t RESULT_NONE = '0;

endpackage

// ===== sv/trr_decode.sv =====
module trr_decode #(
    parameter int COUNT_BITS = 16
) (
    input  trr_pkg::flags_t         flags,
    input  logic [COUNT_BITS-1:0]   count,
    input  logic [15:0]             max_len,
    input  logic [8:0]              symbol,
    output trr_pkg::flags_t         flags_next,
    output logic [COUNT_BITS-1:0]   count_next,
    output logic [1:0]              n_results,
    output trr_pkg::result_t        res0,
    output trr_pkg::result_t        res1
);

    localparam int CW = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    logic [COUNT_BITS-1:0] base;
    logic [COUNT_BITS-1:0] inc;
    logic [CW-1:0]         inc_ext;
    logic [CW-1:0]         cnt_ext;
    logic [CW-1:0]         max_ext;
    logic                  limit_hit;
    logic                  in_rec;
    // outcome of handling the symbol as if seeking
    trr_pkg::flags_t       sk_flags;
    logic [COUNT_BITS-1:0] sk_count;
    logic                  sk_emit;
    trr_pkg::result_t      sk_res;
    trr_pkg::result_t      byte_res;
    trr_pkg::result_t      end_res;

    assign in_rec    = (flags.phase == trr_pkg::PH_REC);
    assign base      = in_rec ? count : '0;
    assign inc       = base + COUNT_BITS'(1);
    assign inc_ext   = CW'(inc);
    assign cnt_ext   = CW'(count);
    assign max_ext   = CW'(max_len);
    assign limit_hit = (inc_ext >= max_ext) || (&inc);

    always_comb
    begin
        byte_res           = trr_pkg::RESULT_NONE;
        byte_res.kind      = trr_pkg::K_DATA;
        byte_res.data_byte = symbol[7:0];

        end_res               = trr_pkg::RESULT_NONE;
        end_res.kind          = trr_pkg::K_END;
        end_res.byte_count    = cnt_ext[15:0];
        end_res.end_of_record = flags.eor_seen;
        end_res.bad_close     = flags.error_seen;
    end

    always_comb
    begin
        sk_flags       = flags;
        sk_flags.phase = trr_pkg::PH_SEEK;
        sk_count       = count;
        sk_emit        = 1'b0;
        sk_res         = trr_pkg::RESULT_NONE;
        if (!symbol[8])
        begin
            if (symbol == trr_pkg::SYM_NULL)
            begin
                sk_emit     = 1'b1;
                sk_res.kind = trr_pkg::K_EOM;
            end
            else if (symbol == trr_pkg::SYM_MARK)
            begin
                sk_emit     = 1'b1;
                sk_res.kind = trr_pkg::K_MARK;
            end
        end
        else
        begin
            sk_flags.eor_seen   = 1'b0;
            sk_flags.error_seen = 1'b0;
            sk_count            = '0;
            sk_emit             = 1'b1;
            if (max_len == 16'd0)
            begin
                sk_res.kind = trr_pkg::K_END;
            end
            else
            begin
                // base is zero whenever this path is taken
                sk_res         = byte_res;
                sk_count       = inc;
                sk_flags.phase = limit_hit ? trr_pkg::PH_TRAIL : trr_pkg::PH_REC;
            end
        end
    end

    always_comb
    begin
        flags_next = flags;
        count_next = count;
        n_results  = 2'd0;
        res0       = trr_pkg::RESULT_NONE;
        res1       = trr_pkg::RESULT_NONE;
        case (flags.phase)
            trr_pkg::PH_REC:
            begin
                if (symbol == trr_pkg::SYM_NULL)
                begin
                    n_results        = 2'd1;
                    res0.kind        = trr_pkg::K_BAD;
                    flags_next.phase = trr_pkg::PH_SEEK;
                end
                else if (symbol == trr_pkg::SYM_EOR || symbol == trr_pkg::SYM_MARK)
                begin
                    flags_next.eor_seen = 1'b1;
                    flags_next.phase    = trr_pkg::PH_TRAIL;
                end
                else if (symbol == trr_pkg::SYM_GAP)
                begin
                    n_results = 2'd0;
                end
                else if (!symbol[8])
                begin
                    flags_next.error_seen = 1'b1;
                    flags_next.phase      = trr_pkg::PH_TRAIL;
                end
                else
                begin
                    n_results        = 2'd1;
                    res0             = byte_res;
                    count_next       = inc;
                    flags_next.phase = limit_hit ? trr_pkg::PH_TRAIL : trr_pkg::PH_REC;
                end
            end
            trr_pkg::PH_TRAIL:
            begin
                if (symbol == trr_pkg::SYM_EOR)
                begin
                    flags_next.eor_seen = 1'b1;
                end
                else
                begin
                    // summary, then the closing symbol handled afresh
                    res0       = end_res;
                    res1       = sk_res;
                    n_results  = sk_emit ? 2'd2 : 2'd1;
                    flags_next = sk_flags;
                    count_next = sk_count;
                end
            end
            default:
            begin
                res0       = sk_res;
                n_results  = sk_emit ? 2'd1 : 2'd0;
                flags_next = sk_flags;
                count_next = sk_count;
            end
        endcase
        res0.last = (n_results == 2'd1);
        res1.last = 1'b1;
    end

endmodule

// ===== sv/trr_result_fifo.sv =====
module trr_result_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [1:0]       push_n,
    input  trr_pkg::result_t push0,
    input  trr_pkg::result_t push1,
    input  logic             pop,
    output logic             not_empty,
    output trr_pkg::result_t head,
    output logic [2:0]       count_next
);

    trr_pkg::result_t mem [4];
    logic [1:0] wr_ptr_reg;
    logic [1:0] rd_ptr_reg;
    logic [2:0] count_reg;
    logic       do_pop;
    logic [1:0] wr_ptr_next;
    logic [1:0] rd_ptr_next;

    assign not_empty   = (count_reg != 3'd0);
    assign head        = mem[rd_ptr_reg];
    assign do_pop      = pop && not_empty;
    assign count_next  = count_reg + 3'(push_n) - 3'(do_pop);
    assign wr_ptr_next = wr_ptr_reg + push_n;
    assign rd_ptr_next = rd_ptr_reg + 2'(do_pop);

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            mem[wr_ptr_reg] <= push0;
        end
        if (push_n == 2'd2)
        begin
            mem[wr_ptr_reg + 2'd1] <= push1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== sv/tape_record_reader.sv =====
// Tape record reader: splits a stream of 9-bit tape symbols (bit 8 set for data) into records,
// giving data bytes, record summaries, tape marks, end of medium and bad tape as results.
// One symbol is taken per cycle while s_tready is high; it is held in the input register, is
// decoded against the record state and its zero to two results land in a four-entry result
// queue. A symbol yielding two results (summary plus the re-handled closing symbol) fills two
// queue entries, so the sustained rate is one symbol per cycle while results average at most
// one per symbol; otherwise it follows the output side at one result per cycle. max_record_len
// resets to 65535; the user must write it through cfg_wen/cfg_wdata only while idle, unchecked.
module tape_record_reader #(
    parameter int COUNT_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wen,
    input  logic [15:0] cfg_wdata,     // max_record_len
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,       // symbol[8:0], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,       // data_byte[7:0], byte_count[23:8],
                                       // end_of_record[24], bad_close[25], zero fill
    output logic [2:0]  m_tuser,       // kind[2:0]
    output logic        m_tlast        // last
);

    logic                  in_valid_reg;
    logic [8:0]            symbol_reg;
    logic [15:0]           max_len_reg;
    trr_pkg::flags_t       flags_reg;
    logic [COUNT_BITS-1:0] count_reg;
    trr_pkg::flags_t       flags_next;
    logic [COUNT_BITS-1:0] count_next;
    logic [1:0]            dec_n;
    logic [1:0]            push_n;
    trr_pkg::result_t      res0;
    trr_pkg::result_t      res1;
    trr_pkg::result_t      head;
    logic [2:0]            fifo_count_next;

    trr_decode #(
        .COUNT_BITS (COUNT_BITS)
    ) u_decode (
        .flags      (flags_reg),
        .count      (count_reg),
        .max_len    (max_len_reg),
        .symbol     (symbol_reg),
        .flags_next (flags_next),
        .count_next (count_next),
        .n_results  (dec_n),
        .res0       (res0),
        .res1       (res1)
    );

    assign push_n = in_valid_reg ? dec_n : 2'd0;

    trr_result_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_n     (push_n),
        .push0      (res0),
        .push1      (res1),
        .pop        (m_tready),
        .not_empty  (m_tvalid),
        .head       (head),
        .count_next (fifo_count_next)
    );

    // room for two more results once this cycle's request has been queued
    assign s_tready = (fifo_count_next <= 3'd2);

    assign m_tdata = {6'd0, head.bad_close, head.end_of_record, head.byte_count, head.data_byte};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            symbol_reg <= s_tdata[8:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            max_len_reg  <= 16'hFFFF;
            flags_reg    <= '0;
            count_reg    <= '0;
        end
        else
        begin
            in_valid_reg <= s_tvalid && s_tready;
            if (cfg_wen)
            begin
                max_len_reg <= cfg_wdata;
            end
            if (in_valid_reg)
            begin
                flags_reg <= flags_next;
                count_reg <= count_next;
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg |-> (fifo_count_next <= 3'd4))
        else $error("result queue overflow");

    a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == trr_pkg::K_DATA) |-> (m_tdata[31:8] == 24'd0))
        else $error("data byte result carries summary fields");

    a_ctrl_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == trr_pkg::K_MARK || m_tuser == trr_pkg::K_EOM
                      || m_tuser == trr_pkg::K_BAD)) |-> (m_tdata == 32'd0))
        else $error("control result carries payload");

    a_two_only_from_trailer: assert property (@(posedge clk) disable iff (!rst_n)
        (push_n == 2'd2) |-> (flags_reg.phase == trr_pkg::PH_TRAIL))
        else $error("two results outside trailer");

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int SETTLE_CYCLES = 8;

    class record_scoreboard;
        trr_pkg::result_t expected_q[$];
        trr_pkg::result_t fresh_q[$];
        logic [1:0]  phase;
        logic [15:0] rec_len;
        logic        eor_flag;
        logic        err_flag;
        logic [15:0] max_len;
        int          errors;

        function new();
            phase    = trr_pkg::PH_SEEK;
            rec_len  = '0;
            eor_flag = 1'b0;
            err_flag = 1'b0;
            max_len  = 16'hFFFF;
            errors   = 0;
        endfunction

        function void emit(logic [2:0] kind, logic [7:0] data, logic [15:0] count,
                           logic eor, logic err);
            trr_pkg::result_t r;
            r.kind          = kind;
            r.data_byte     = data;
            r.byte_count    = count;
            r.end_of_record = eor;
            r.bad_close     = err;
            r.last          = 1'b0;
            fresh_q.push_back(r);
        endfunction

        function void take_byte(logic [8:0] sym);
            emit(trr_pkg::K_DATA, sym[7:0], 16'd0, 1'b0, 1'b0);
            rec_len = rec_len + 16'd1;
            // cut on the length limit or when the counter is full
            if (rec_len >= max_len || rec_len == 16'hFFFF)
                phase = trr_pkg::PH_TRAIL;
            else
                phase = trr_pkg::PH_REC;
        endfunction

        function void seek(logic [8:0] sym);
            if (!sym[8]) begin
                if (sym == trr_pkg::SYM_NULL)
                    emit(trr_pkg::K_EOM, 8'd0, 16'd0, 1'b0, 1'b0);
                else if (sym == trr_pkg::SYM_MARK)
                    emit(trr_pkg::K_MARK, 8'd0, 16'd0, 1'b0, 1'b0);
                phase = trr_pkg::PH_SEEK;
            end
            else begin
                rec_len  = '0;
                eor_flag = 1'b0;
                err_flag = 1'b0;
                if (max_len == 16'd0) begin
                    // zero limit: the byte is dropped, an empty summary goes out
                    emit(trr_pkg::K_END, 8'd0, 16'd0, 1'b0, 1'b0);
                    phase = trr_pkg::PH_SEEK;
                end
                else
                    take_byte(sym);
            end
        endfunction

        // work out what one accepted request causes and queue it
        function void note_symbol(logic [8:0] sym);
            trr_pkg::result_t tail;
            fresh_q.delete();
            if (phase == trr_pkg::PH_REC) begin
                if (sym == trr_pkg::SYM_NULL) begin
                    emit(trr_pkg::K_BAD, 8'd0, 16'd0, 1'b0, 1'b0);
                    phase = trr_pkg::PH_SEEK;
                end
                else if (sym == trr_pkg::SYM_EOR || sym == trr_pkg::SYM_MARK) begin
                    eor_flag = 1'b1;
                    phase    = trr_pkg::PH_TRAIL;
                end
                else if (sym == trr_pkg::SYM_GAP) begin
                end
                else if (!sym[8]) begin
                    err_flag = 1'b1;
                    phase    = trr_pkg::PH_TRAIL;
                end
                else
                    take_byte(sym);
            end
            else if (phase == trr_pkg::PH_TRAIL) begin
                if (sym == trr_pkg::SYM_EOR)
                    eor_flag = 1'b1;
                else begin
                    emit(trr_pkg::K_END, 8'd0, rec_len, eor_flag, err_flag);
                    phase = trr_pkg::PH_SEEK;
                    seek(sym);
                end
            end
            else
                seek(sym);

            if (fresh_q.size() > 0) begin
                tail = fresh_q.pop_back();
                tail.last = 1'b1;
                fresh_q.push_back(tail);
            end
            foreach (fresh_q[i])
                expected_q.push_back(fresh_q[i]);
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        task check_result(logic [2:0] kind, logic [31:0] tdata, logic tlast);
            trr_pkg::result_t want;
            logic    bad;
            string   got_s;
            string   want_s;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0d tdata %h last %b",
                                          kind, tdata, tlast));
            end
            else begin
                want = expected_q.pop_front();
                bad  = 1'b0;
                if (kind != want.kind)                 bad = 1'b1;
                if (tdata[7:0] != want.data_byte)      bad = 1'b1;
                if (tdata[23:8] != want.byte_count)    bad = 1'b1;
                if (tdata[24] != want.end_of_record)   bad = 1'b1;
                if (tdata[25] != want.bad_close)       bad = 1'b1;
                if (tdata[31:26] != 6'd0)              bad = 1'b1;
                if (tlast != want.last)                bad = 1'b1;
                if (bad) begin
                    got_s = $sformatf(
                        "got kind %0d byte %h count %0d eor %b err %b last %b pad %h",
                        kind, tdata[7:0], tdata[23:8], tdata[24], tdata[25], tlast,
                        tdata[31:26]);
                    want_s = $sformatf(
                        "want kind %0d byte %h count %0d eor %b err %b last %b",
                        want.kind, want.data_byte, want.byte_count,
                        want.end_of_record, want.bad_close, want.last);
                    report_mismatch({got_s, ", ", want_s});
                end
            end
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wen = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    record_scoreboard sb = new();

    int cycles = 0;
    int burst_left = 0;
    int sent = 0;
    int stall_left = 0;
    int stall_mode = 0;

    tape_record_reader #(.COUNT_BITS(16)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver: picks a new stall pattern whenever its countdown runs out
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
        end
        else
            stall_left--;
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            2:       m_tready <= ($urandom_range(0, 1) == 1);
            default: m_tready <= (stall_left[2:0] != 3'd0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata, m_tlast);
    end

    task send_sym(input logic [8:0] sym);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, sym};
        // hold the request until the block takes it
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_symbol(sym);
        burst_left--;
        sent++;
    endtask

    task settle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task write_max_len(input logic [15:0] value);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wen <= 1'b0;
        sb.max_len = value;
    endtask

    function logic [8:0] odd_control();
        logic [8:0] v;
        v = 9'($urandom_range(1, 255));
        while (v == trr_pkg::SYM_MARK || v == trr_pkg::SYM_EOR || v == trr_pkg::SYM_GAP)
            v = 9'($urandom_range(1, 255));
        return v;
    endfunction

    task send_record();
        int len;
        int closer;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_sym(trr_pkg::SYM_GAP);
            send_sym({1'b1, 8'($urandom)});
        end
        closer = $urandom_range(0, 9);
        if (closer <= 3)
            send_sym(trr_pkg::SYM_EOR);
        else if (closer <= 5)
            send_sym(trr_pkg::SYM_MARK);
        else if (closer <= 7)
            send_sym(odd_control());
        else if (closer == 8)
            send_sym(trr_pkg::SYM_NULL);
        repeat ($urandom_range(0, 3)) send_sym(trr_pkg::SYM_EOR);
    endtask

    task run_random(input int count);
        int target;
        int pick;
        target = sent + count;
        while (sent < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                send_record();
            else if (pick < 85)
                send_sym(9'($urandom_range(0, 511)));
            else
            begin
                case ($urandom_range(0, 4))
                    0:       send_sym(trr_pkg::SYM_NULL);
                    1:       send_sym(trr_pkg::SYM_MARK);
                    2:       send_sym(trr_pkg::SYM_EOR);
                    3:       send_sym(trr_pkg::SYM_GAP);
                    default: send_sym(odd_control());
                endcase
            end
        end
    endtask

    logic [8:0]  opening[18] = '{
        9'h000, 9'h000, 9'h01C, 9'h055, 9'h1FF, 9'h07F, 9'h100, 9'h01E, 9'h01E,
        9'h000, 9'h180, 9'h033, 9'h01C, 9'h1AA, 9'h000, 9'h155, 9'h01C, 9'h1FE
    };
    logic [15:0] plan[8];

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_max_len(16'hFFFF);
        foreach (opening[i])
            send_sym(opening[i]);

        // zero limit, then a limit of one byte
        settle();
        write_max_len(16'd0);
        send_sym(9'h1AB);
        send_sym(9'h0FF);
        settle();
        write_max_len(16'd1);
        send_sym(9'h101);
        send_sym(9'h102);
        send_sym(trr_pkg::SYM_EOR);

        plan = '{16'd0, 16'd1, 16'd2, 16'd3, 16'($urandom_range(4, 20)), 16'hFFFF,
                 16'($urandom), 16'd7};
        foreach (plan[i])
        begin
            settle();
            write_max_len(plan[i]);
            run_random(140);
        end

        settle();
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
